[rtl/ilir_pkg.sv]
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and codes for the indexed list
// Item layouts, operation and status codes, and the control bundle that the
// top level broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 7;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [VALUE_BITS-1:0] VALUE_ERR = '1;

    typedef struct packed {
        logic [1:0]                   operation;
        logic [POS_BITS-1:0]          position;
        logic signed [VALUE_BITS-1:0] value_in;
    } t_op_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value_out;
        logic [1:0]                   status;
        logic [POS_BITS-1:0]          count_after;
    } t_result_item;

    // Update command seen by every cell in the same cycle.
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic [VALUE_BITS-1:0] value;
    } t_cell_ctl;

endpackage

[rtl/ilir_cell.sv]
// ----------------------------------------------------------------------------
// ilir_cell: one slot of the indexed list
// Holds one entry. On an insert it takes the new value at the insert point,
// its lower neighbor's entry above it; on a remove, its upper neighbor's
// entry at or above the removal point. It also offers its entry for reads.
// ----------------------------------------------------------------------------
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int PW    = 7
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [PW-1:0]         i_pos,
    input  logic [VALUE_BITS-1:0] i_left,
    input  logic [VALUE_BITS-1:0] i_right,
    output logic [VALUE_BITS-1:0] o_entry,
    output logic [VALUE_BITS-1:0] o_tap
);

    localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

    logic [VALUE_BITS-1:0] r_entry;
    logic [VALUE_BITS-1:0] n_entry;
    logic                  w_exact;
    logic                  w_above;

    assign w_exact = (MY_INDEX == i_pos);
    assign w_above = (MY_INDEX > i_pos);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (w_exact) begin
                n_entry = i_ctl.value;
            end else if (w_above) begin
                n_entry = i_left;
            end
        end else if (i_ctl.rem) begin
            if (w_exact || w_above) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = w_exact ? r_entry : '0;

endmodule

[rtl/indexed_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: ordered list with get, insert and remove
// An ordered list of signed entries held in a row of cells that shift
// together, so an insert or remove moves every later entry at once.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one operation
//   per item: get, insert or remove at a position. Output channel
//   (o_out_valid / i_out_ready / o_out_item) returns exactly one result item
//   per input item: the value, a status and the entry count afterwards.
//   An accepted item is registered in the command register, then executed
//   against the cell row once the output register has room; the execute
//   step loads the output register, from which the receiver takes the result.
//   A new item is taken in the same cycle that the previous one executes, so
//   one item per cycle is sustained while the receiver takes results. The
//   execute step waits for room in the output register; while the receiver
//   stalls, one item waits in the command register and o_in_ready drops
//   behind it.
//   Reset empties the list (count zero) and drops any pending item or result.
//   Cell contents are not cleared; slots at or above the count are never read.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_op_item     i_in_item,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_result_item o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic                  r_busy;
    t_op_item              r_cmd;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    t_result_item          r_out;
    t_result_item          n_out;

    logic                  w_accept;
    logic                  w_exec;
    logic [PW-1:0]         w_pos;
    logic [PW-1:0]         w_cnt;
    logic                  w_do_ins;
    logic                  w_do_rem;
    logic [VALUE_BITS-1:0] w_read;
    t_cell_ctl             w_ctl;

    logic [VALUE_BITS-1:0] w_entry [DEPTH];
    logic [VALUE_BITS-1:0] w_tap   [DEPTH];

    assign w_exec     = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || w_exec;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_pos = PW'(r_cmd.position);
    assign w_cnt = PW'(r_count);

    // Decode the pending operation against the current count.
    always_comb begin
        w_do_ins          = 1'b0;
        w_do_rem          = 1'b0;
        n_count           = r_count;
        n_out.value_out   = VALUE_ERR;
        n_out.status      = ST_RANGE;
        unique case (r_cmd.operation)
            OP_GET: begin
                if (w_pos < w_cnt) begin
                    n_out.value_out = w_read;
                    n_out.status    = ST_OK;
                end
            end
            OP_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_out.status = ST_RANGE;
                end else if (r_count == FULL_COUNT) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_do_ins        = 1'b1;
                    n_count         = r_count + 1'b1;
                    n_out.value_out = '0;
                    n_out.status    = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (w_pos < w_cnt) begin
                    w_do_rem        = 1'b1;
                    n_count         = r_count - 1'b1;
                    n_out.value_out = w_read;
                    n_out.status    = ST_OK;
                end
            end
            default: begin
                n_out.status = ST_RANGE;
            end
        endcase
        n_out.count_after = POS_BITS'(n_count);
    end

    assign w_ctl.ins   = w_exec && w_do_ins;
    assign w_ctl.rem   = w_exec && w_do_rem;
    assign w_ctl.value = r_cmd.value_in;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VALUE_BITS-1:0] w_left;
            logic [VALUE_BITS-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[gi+1];
            end
            ilir_cell #(
                .INDEX (gi),
                .PW    (PW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (w_pos),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[gi]),
                .o_tap   (w_tap[gi])
            );
        end
    endgenerate

    // At most one cell matches the position, so an OR picks its entry.
    always_comb begin
        w_read = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_read = w_read | w_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_item;
        end
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count exceeds capacity");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the count by one");

    a_remove_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not shrink the count by one");

    a_result_from_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_exec))
        else $error("result appeared without an executed item");

    a_status_legal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_OK || o_out_item.status == ST_RANGE
                         || o_out_item.status == ST_FULL))
        else $error("illegal status code on output");

endmodule
